// ----- hw/rtl/psh_pkg.sv -----
// ----------------------------------------------------------------------------
// psh_pkg: shared constants for the symbol hash block
// Field widths, default table size and the fixed 8-bit permutation table.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

	localparam int CHAR_W         = 8;
	localparam int IDX_W          = 10;
	localparam int HASH_W         = 16;
	localparam int PERM_DEPTH     = 256;
	localparam int TABLE_SIZE_DEF = 1024;

	// Pearson permutation of the byte values
	localparam logic [CHAR_W-1:0] PERM_TBL [PERM_DEPTH] = '{
		8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
		8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
		8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
		8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
		8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
		8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
		8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
		8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
		8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
		8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
		8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
		8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
		8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
		8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
		8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
		8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
		8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
		8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
		8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
		8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
		8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
		8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
		8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
		8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
		8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
		8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
		8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
		8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
		8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
		8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
		8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
		8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
	};

endpackage

`default_nettype wire

// ----- hw/rtl/psh_ram.sv -----
// ----------------------------------------------------------------------------
// psh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pearson_symbol_hash.sv -----
// ----------------------------------------------------------------------------
// pearson_symbol_hash: streaming Pearson hash of an identifier, 16 bits for tables over 256
// Two permutation chains over RAM copies of the table, then the joined hash
// is reduced modulo the table size in a short elastic pipeline.
// ----------------------------------------------------------------------------
//
//  channel | signals                      | direction | carries
//  --------+------------------------------+-----------+--------------------------
//  in      | in_valid in_ready            | to block  | char_byte, is_last
//  out     | out_valid out_ready          | from block| bucket_index (last byte)
//
// One byte item is taken every cycle while in_ready is high. The registered
// read data of each permutation RAM is XORed with the next byte and goes
// straight back to the read address.
// After its last byte is taken, a result passes through the registered steps
// lookup and join, reciprocal multiply, quotient times size, and subtract and
// correct, and then waits in the output register until out_ready takes it.
// After reset a fill pass loads all 256 entries into both permutation RAMs;
// no item is taken during it.
// Bytes keep flowing while results wait; input stalls only during the fill
// pass or when a finished hash has no free pipeline slot ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module pearson_symbol_hash #(
	parameter int TABLE_SIZE = psh_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [psh_pkg::CHAR_W-1:0] char_byte,
	input  wire logic                       is_last,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [psh_pkg::IDX_W-1:0]  bucket_index
);

	import psh_pkg::*;

	localparam int AW       = $clog2(PERM_DEPTH);
	localparam int SZ_W     = HASH_W + 1;
	localparam bit WIDE_HASH = (TABLE_SIZE > PERM_DEPTH);
	// floor(2^32 / size): quotient estimate is exact or one short
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SIZE));
	localparam logic [SZ_W-1:0] TSIZE = SZ_W'(TABLE_SIZE);

	// ---------------------------------------------------------------- fill pass
	logic [AW:0] fill_q;
	logic        filling;

	assign filling = !fill_q[AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (filling) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// ------------------------------------------------------------ chain state
	// Raw registers keep the final values of the last item so the hash stage
	// can read them; fresh_q masks them to the reset state for the next one.
	logic [CHAR_W-1:0] main_q, second_q;
	logic              main_pend_q, second_pend_q;
	logic              seen_q, stop_q, fresh_q;
	logic [CHAR_W-1:0] main_rd, second_rd;
	logic [CHAR_W-1:0] main_fin, second_fin;
	logic [CHAR_W-1:0] main_cur, second_cur;
	logic              seen_cur, stop_cur;
	logic              accept, zero_byte, do_lookup;
	logic              main_re, second_re;
	logic [AW-1:0]     main_addr, second_addr;

	assign main_fin   = main_pend_q ? main_rd : main_q;
	assign second_fin = second_pend_q ? second_rd : second_q;
	assign main_cur   = fresh_q ? '0 : main_fin;
	assign second_cur = fresh_q ? '0 : second_fin;
	assign seen_cur   = !fresh_q && seen_q;
	assign stop_cur   = !fresh_q && stop_q;

	assign accept    = in_valid && in_ready;
	assign zero_byte = (char_byte == '0);
	assign do_lookup = !stop_cur && !zero_byte;

	assign main_re     = accept && do_lookup;
	assign second_re   = accept && do_lookup && seen_cur;
	assign main_addr   = main_cur ^ char_byte;
	assign second_addr = second_cur ^ char_byte;

	psh_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (PERM_DEPTH)
	) u_main_ram (
		.clk   (clk),
		.we    (filling),
		.waddr (fill_q[AW-1:0]),
		.wdata (PERM_TBL[fill_q[AW-1:0]]),
		.re    (main_re),
		.raddr (main_addr),
		.rdata (main_rd)
	);

	psh_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (PERM_DEPTH)
	) u_second_ram (
		.clk   (clk),
		.we    (filling),
		.waddr (fill_q[AW-1:0]),
		.wdata (PERM_TBL[fill_q[AW-1:0]]),
		.re    (second_re),
		.raddr (second_addr),
		.rdata (second_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_pend_q   <= 1'b0;
			second_pend_q <= 1'b0;
			seen_q        <= 1'b0;
			stop_q        <= 1'b0;
			fresh_q       <= 1'b1;
		end else if (accept) begin
			main_pend_q   <= do_lookup;
			second_pend_q <= do_lookup && seen_cur;
			seen_q        <= seen_cur || do_lookup;
			stop_q        <= stop_cur || zero_byte;
			// next identifier starts from reset after its last byte
			fresh_q       <= is_last;
		end else begin
			main_pend_q   <= 1'b0;
			second_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			main_q <= main_cur;
			if (do_lookup && !seen_cur) begin
				// second chain seeds from the first byte plus one
				second_q <= char_byte + 1'b1;
			end else begin
				second_q <= second_cur;
			end
		end else begin
			// capture the lookup result so the RAM output may move on
			main_q   <= main_fin;
			second_q <= second_fin;
		end
	end

	// ------------------------------------------------------- modulo pipeline
	logic              res_v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic              out_free, s4_free, s3_free, s2_free;
	logic [HASH_W-1:0] hash_c;
	logic [HASH_W-1:0] hash_s2, hash_s3, hash_s4;
	logic [HASH_W-1:0] quot_s3;
	logic [SZ_W-1:0]   qt_s4;
	logic [SZ_W-1:0]   diff, rem;
	logic [IDX_W-1:0]  bucket_q;

	assign out_free = !out_valid_q || out_ready;
	assign s4_free  = !v_s4 || out_free;
	assign s3_free  = !v_s3 || s4_free;
	assign s2_free  = !v_s2 || s3_free;

	// hold input while a finished hash cannot move on
	assign in_ready = !filling && (!res_v_s1 || s2_free);

	assign hash_c = (WIDE_HASH && seen_q) ? {main_fin, second_fin}
	                                      : HASH_W'(main_fin);

	assign diff = SZ_W'(hash_s4) - qt_s4;
	assign rem  = (diff >= TSIZE) ? (diff - TSIZE) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1    <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			res_v_s1 <= (accept && is_last) || (res_v_s1 && !s2_free);
			if (s2_free) begin
				v_s2 <= res_v_s1;
			end
			if (s3_free) begin
				v_s3 <= v_s2;
			end
			if (s4_free) begin
				v_s4 <= v_s3;
			end
			if (out_free) begin
				out_valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && res_v_s1) begin
			hash_s2 <= hash_c;
		end
		if (s3_free && v_s2) begin
			hash_s3 <= hash_s2;
			quot_s3 <= HASH_W'((48'(hash_s2) * 48'(RECIP)) >> 32);
		end
		if (s4_free && v_s3) begin
			hash_s4 <= hash_s3;
			qt_s4   <= SZ_W'(33'(quot_s3) * 33'(TSIZE));
		end
		if (out_free && v_s4) begin
			bucket_q <= rem[IDX_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pearson_symbol_hash
// Streams identifiers one byte item at a time with random gaps and output
// stalls. A predictor built from the permutation table keeps both hash chains
// and queues the bucket expected on every last byte. Each bucket item that
// leaves the block is compared with the oldest one in that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import psh_pkg::*;

	localparam int TBL_SIZE    = TABLE_SIZE_DEF;
	localparam int RANDOM_ITEMS = 1950;
	localparam int MAX_ID_LEN  = 48;
	localparam int DRAIN_CYCLES = 20;

	// One row of the directed part. Where known is set, the bucket is typed in
	// and replaces the predicted one; otherwise the predictor decides.
	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              last;
		logic              known;
		logic [IDX_W-1:0]  bucket;
	} stim_row_t;

	localparam int N_DIRECTED = 19;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// empty identifier gives bucket 0
		'{8'h00, 1'b1, 1'b1, 10'd0},
		// zero byte freezes the chains, the later byte is ignored
		'{8'h00, 1'b0, 1'b0, 10'd0},
		'{8'hff, 1'b1, 1'b1, 10'd0},
		// single byte: top chain is the table entry, second chain wraps to 0
		'{8'hff, 1'b1, 1'b1, 10'd256},
		// single byte 0x01: entry 87 over second chain 2
		'{8'h01, 1'b1, 1'b1, 10'd770},
		// ordinary three-letter name
		'{8'h41, 1'b0, 1'b0, 10'd0},
		'{8'h42, 1'b0, 1'b0, 10'd0},
		'{8'h43, 1'b1, 1'b0, 10'd0},
		// zero in the middle, last byte must not move the chains
		'{8'h5a, 1'b0, 1'b0, 10'd0},
		'{8'h00, 1'b0, 1'b0, 10'd0},
		'{8'h7f, 1'b1, 1'b0, 10'd0},
		// all ones
		'{8'hff, 1'b0, 1'b0, 10'd0},
		'{8'hff, 1'b0, 1'b0, 10'd0},
		'{8'hff, 1'b0, 1'b0, 10'd0},
		'{8'hff, 1'b1, 1'b0, 10'd0},
		// zero as the last byte itself
		'{8'h80, 1'b0, 1'b0, 10'd0},
		'{8'h01, 1'b0, 1'b0, 10'd0},
		'{8'h00, 1'b1, 1'b0, 10'd0},
		// single byte after all that, checks the state went back to reset
		'{8'h01, 1'b1, 1'b1, 10'd770}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CHAR_W-1:0]   char_byte;
	logic                is_last;
	logic                out_valid;
	logic                out_ready;
	logic [IDX_W-1:0]    bucket_index;

	// predictor state
	logic [CHAR_W-1:0]   chain_a;
	logic [CHAR_W-1:0]   chain_b;
	bit                  have_first;
	bit                  frozen;

	logic [IDX_W-1:0]    pending_buckets [$];
	int                  error_count;
	int                  sent_count;
	int                  taken_count;

	pearson_symbol_hash #(
		.TABLE_SIZE(TBL_SIZE)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bucket_index(bucket_index)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		error_count++;
	endtask

	// Advance both chains by one accepted byte; on the last byte return the
	// bucket and drop back to the reset state.
	task automatic hash_byte(input logic [CHAR_W-1:0] b, input logic last,
			output bit done, output logic [IDX_W-1:0] bucket);
		int joined;
		if (!frozen) begin
			if (b == '0) begin
				frozen = 1'b1;
			end else begin
				chain_a = PERM_TBL[chain_a ^ b];
				if (!have_first) begin
					chain_b    = b + 8'd1;
					have_first = 1'b1;
				end else begin
					chain_b = PERM_TBL[chain_b ^ b];
				end
			end
		end
		done   = last;
		bucket = '0;
		if (last) begin
			joined = int'(chain_a);
			if (TBL_SIZE > PERM_DEPTH && have_first)
				joined = (joined << 8) | int'(chain_b);
			joined = joined % TBL_SIZE;
			bucket = joined[IDX_W-1:0];
			chain_a    = '0;
			chain_b    = '0;
			have_first = 1'b0;
			frozen     = 1'b0;
		end
	endtask

	// Offer one byte item after a drawn gap and hold it until taken. Valid is
	// left high on return; the caller drops it when no item follows at once.
	task automatic send_byte(input logic [CHAR_W-1:0] b, input logic last,
			input bit use_known, input logic [IDX_W-1:0] known_bucket);
		int gap;
		bit done;
		logic [IDX_W-1:0] bucket;
		gap = (((sent_count / 150) % 4) == 2) ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_byte <= b;
		is_last   <= last;
		do @(posedge clk); while (!in_ready);
		sent_count++;
		hash_byte(b, last, done, bucket);
		if (done)
			pending_buckets.push_back(use_known ? known_bucket : bucket);
	endtask

	// Stimulus
	initial begin
		logic [CHAR_W-1:0] id_bytes [MAX_ID_LEN];
		int id_len;
		int kind;
		int zero_at;
		bit paused;

		chain_a     = '0;
		chain_b     = '0;
		have_first  = 1'b0;
		frozen      = 1'b0;
		error_count = 0;
		sent_count  = 0;
		paused      = 1'b0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		char_byte <= '0;
		is_last   <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		for (int r = 0; r < N_DIRECTED; r++)
			send_byte(DIRECTED[r].chr, DIRECTED[r].last, DIRECTED[r].known,
				DIRECTED[r].bucket);

		// Random identifiers: mostly well formed, some empty, some broken by
		// a zero byte somewhere inside
		sent_count = 0;
		while (sent_count < RANDOM_ITEMS) begin
			kind   = $urandom_range(0, 19);
			id_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_ID_LEN)
				: $urandom_range(1, 12);
			for (int i = 0; i < id_len; i++)
				id_bytes[i] = CHAR_W'($urandom_range(1, 255));
			if (kind == 0) begin
				id_len      = $urandom_range(1, 3);
				id_bytes[0] = '0;
			end else if (kind <= 3) begin
				zero_at = $urandom_range(0, id_len - 1);
				id_bytes[zero_at] = '0;
				for (int i = zero_at + 1; i < id_len; i++)
					id_bytes[i] = CHAR_W'($urandom_range(0, 255));
			end
			for (int i = 0; i < id_len; i++)
				send_byte(id_bytes[i], i == id_len - 1, 1'b0, '0);

			// Hold off once until every bucket so far has come back
			if (!paused && sent_count >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (pending_buckets.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending_buckets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("pearson_symbol_hash: match");
		end else begin
			$display("pearson_symbol_hash: mismatch");
		end
		$finish;
	end

	// Receiver: stall a drawn number of cycles before each bucket item, with
	// calm stretches where ready stays high
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = (((taken_count / 20) % 4) == 1) ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare every bucket item taken with the oldest one waiting
	initial taken_count = 0;
	always @(posedge clk) begin
		logic [IDX_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			taken_count++;
			if (pending_buckets.size() == 0) begin
				report_mismatch($sformatf("bucket %0d with none expected", bucket_index));
			end else begin
				want = pending_buckets.pop_front();
				if (bucket_index !== want)
					report_mismatch($sformatf("bucket %0d, expected %0d",
						bucket_index, want));
			end
		end
	end

	// Time limit
	initial begin
		#10_000_000;
		$display("pearson_symbol_hash: mismatch");
		$finish;
	end

endmodule
